// ===== design/adcvm_pkg.sv =====
// ----------------------------------------------------------------------------
// adcvm_pkg
// shared constants and a lookup function for the voltmeter display scanner
// ----------------------------------------------------------------------------
package adcvm_pkg;

  localparam int NUM_DIGITS_DEF = 8;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_H     = 8'h76;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] SEL_OFF   = 8'hff;

  // 125*n - 16000 as signed tenths times 128
  localparam logic signed [15:0] SCALE_MUL = 16'sd125;
  localparam logic signed [15:0] OFFSET    = 16'sd16000;

  // hex font, common cathode, bit 7 is the decimal point
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'h0: f = 8'h3f;
      4'h1: f = 8'h06;
      4'h2: f = 8'h5b;
      4'h3: f = 8'h4f;
      4'h4: f = 8'h66;
      4'h5: f = 8'h6d;
      4'h6: f = 8'h7d;
      4'h7: f = 8'h07;
      4'h8: f = 8'h7f;
      4'h9: f = 8'h6f;
      4'ha: f = 8'h77;
      4'hb: f = 8'h7c;
      4'hc: f = 8'h39;
      4'hd: f = 8'h5e;
      4'he: f = 8'h79;
      4'hf: f = 8'h71;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

// ===== design/adc_voltmeter_seven_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// adc_voltmeter_seven_segment_scanner
// multiplexed seven-segment voltmeter display with serial echo of samples
// ----------------------------------------------------------------------------
// an accepted word is registered in stage 1, then in the output register as its result word
// throughput: one word per cycle while the output side does not stall
// the rate is set by the two-stage path: scaling multiply, then digit split
// and the segment buffer write or the registered buffer read
// reset (synchronous, rst high): scan index zero, pipeline empty, buffer reads blank
// ----------------------------------------------------------------------------
module adc_voltmeter_seven_segment_scanner #(
  parameter int NUM_DIGITS = adcvm_pkg::NUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] sample,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] seg_code,
  output logic [7:0] digit_select,
  output logic       display_valid,
  output logic       start_conversion,
  output logic [7:0] tx_byte,
  output logic       tx_valid
);

  localparam int IDX_W  = $clog2(NUM_DIGITS);
  localparam int SCAN_W = IDX_W + 1;

  // buffer entry layout
  localparam int E_H     = 0;
  localparam int E_HEXLO = 1;
  localparam int E_HEXHI = 2;
  localparam int E_GAP   = 3;
  localparam int E_TENTH = 4;
  localparam int E_UNIT  = 5;
  localparam int E_TENS  = 6;
  localparam int E_SIGN  = 7;

  // handshake
  logic in_acc;
  logic advance;

  // scan counter, can sit at NUM_DIGITS which marks the wrap point
  logic [SCAN_W-1:0] scan_index;
  logic [SCAN_W-1:0] scan_index_next;
  logic [IDX_W-1:0]  show_idx;
  logic              wrap;

  // stage 1
  logic                    s1_valid;
  logic                    s1_op;
  logic [7:0]              s1_n;
  logic signed [15:0]      s1_t;
  logic [IDX_W-1:0]        s1_idx;
  logic                    s1_start;

  // segment buffer, registered read
  logic [7:0] seg_mem [NUM_DIGITS];
  logic       loaded;
  logic [7:0] new_code [NUM_DIGITS];

  // digit split
  logic signed [15:0] t_bias;
  logic signed [15:0] v_wide;
  logic signed [7:0]  v;
  logic               neg;
  logic [6:0]         mag;
  logic [17:0]        q1_prod;
  logic [3:0]         q1;
  logic [3:0]         r0;
  logic               q2;
  logic [3:0]         r1;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_acc   = in_valid && !in_stall;

  // scan index: past the last digit restarts at digit 0 with a start pulse
  always_comb begin
    wrap = (scan_index >= SCAN_W'(NUM_DIGITS));
    if (wrap) begin
      show_idx        = '0;
      scan_index_next = SCAN_W'(1);
    end else begin
      show_idx        = scan_index[IDX_W-1:0];
      scan_index_next = scan_index + SCAN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
    end else if (in_acc && op == adcvm_pkg::OP_TICK) begin
      scan_index <= scan_index_next;
    end
  end

  // stage 1: register the word and the scaled sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op    <= op;
      s1_n     <= sample;
      s1_t     <= adcvm_pkg::SCALE_MUL * $signed({8'd0, sample})
                  - adcvm_pkg::OFFSET;
      s1_idx   <= show_idx;
      s1_start <= wrap;
    end
  end

  // divide by 128 truncating toward zero, then split |v| into decimal digits
  always_comb begin
    t_bias  = s1_t + (s1_t[15] ? 16'sd127 : 16'sd0);
    v_wide  = t_bias >>> 7;
    v       = v_wide[7:0];
    neg     = v[7];
    mag     = neg ? 7'(-v) : v[6:0];
    // mag / 10 by reciprocal, exact for mag below 128
    q1_prod = 18'(mag) * 18'd205;
    q1      = q1_prod[14:11];
    r0      = 4'(7'(mag) - 7'(q1) * 7'd10);
    q2      = (q1 >= 4'd10);
    r1      = q2 ? (q1 - 4'd10) : q1;
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      new_code[i] = adcvm_pkg::SEG_BLANK;
    end
    new_code[E_H]     = adcvm_pkg::SEG_H;
    new_code[E_HEXLO] = adcvm_pkg::seg_font(s1_n[3:0]);
    new_code[E_HEXHI] = adcvm_pkg::seg_font(s1_n[7:4]);
    new_code[E_GAP]   = adcvm_pkg::SEG_BLANK;
    new_code[E_TENTH] = adcvm_pkg::seg_font(r0);
    new_code[E_UNIT]  = adcvm_pkg::seg_font(r1) | adcvm_pkg::SEG_DP;
    new_code[E_TENS]  = adcvm_pkg::seg_font({3'd0, q2});
    new_code[E_SIGN]  = neg ? adcvm_pkg::SEG_MINUS : adcvm_pkg::SEG_BLANK;
  end

  // a sample rewrites the whole buffer as it leaves stage 1; a later tick
  // reads the buffer only after that write has landed, so no bypass is needed
  always_ff @(posedge clk) begin
    if (s1_valid && advance && s1_op == adcvm_pkg::OP_SAMPLE) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_mem[i] <= new_code[i];
      end
    end
  end

  // stands in for the cleared buffer until the first sample
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (s1_valid && advance && s1_op == adcvm_pkg::OP_SAMPLE) begin
      loaded <= 1'b1;
    end
  end

  // stage 2: output register, buffer read data lands here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1_op == adcvm_pkg::OP_SAMPLE) begin
        seg_code         <= adcvm_pkg::SEG_BLANK;
        digit_select     <= adcvm_pkg::SEL_OFF;
        display_valid    <= 1'b0;
        start_conversion <= 1'b0;
        tx_byte          <= s1_n;
        tx_valid         <= 1'b1;
      end else begin
        seg_code         <= loaded ? seg_mem[s1_idx] : adcvm_pkg::SEG_BLANK;
        digit_select     <= ~(8'd1 << s1_idx);
        display_valid    <= 1'b1;
        start_conversion <= s1_start;
        tx_byte          <= 8'd0;
        tx_valid         <= 1'b0;
      end
    end
  end

endmodule

// ===== design/adcvm_checker.sv =====
// ----------------------------------------------------------------------------
// adcvm_checker
// port-level checks on the voltmeter display scanner
// ----------------------------------------------------------------------------
module adcvm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] seg_code,
  input logic [7:0] digit_select,
  input logic       display_valid,
  input logic       start_conversion,
  input logic [7:0] tx_byte,
  input logic       tx_valid
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seg_code) && $stable(tx_byte))
    else $error("stalled result changed");

  // an empty output side never backs up the input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a scan word selects exactly one digit and carries no serial byte
  a_scan: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_valid |-> $countones(~digit_select) == 1 && !tx_valid)
    else $error("bad scan word");

  // a sample word blanks the display side
  a_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> digit_select == 8'hff && seg_code == 8'h00
      && !display_valid && !start_conversion)
    else $error("bad sample word");

  // start pulses only with digit 0
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_conversion |-> digit_select == 8'hfe)
    else $error("start away from digit 0");

endmodule

bind adc_voltmeter_seven_segment_scanner adcvm_checker u_adcvm_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .seg_code         (seg_code),
  .digit_select     (digit_select),
  .display_valid    (display_valid),
  .start_conversion (start_conversion),
  .tx_byte          (tx_byte),
  .tx_valid         (tx_valid)
);

// ===== tb/sv/adc_voltmeter_seven_segment_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_voltmeter_seven_segment_scanner_tb
// drives scan ticks and converter samples through the voltmeter display
// scanner with random gaps on both channels, predicts every result word from
// an internal model of the segment buffer and scan index, and compares each
// delivered word field by field in order of arrival
// ----------------------------------------------------------------------------
module adc_voltmeter_seven_segment_scanner_tb;

  localparam int NUM_DIGITS   = adcvm_pkg::NUM_DIGITS_DEF;
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 10;    // pipeline drain plus margin

  // hex font, common cathode; element i is the glyph of digit i
  localparam logic [15:0][7:0] DIGIT_GLYPH = {
    8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  // one input word with its pacing controls
  typedef struct {
    logic       op;
    logic [7:0] sample;
    bit         drain;  // hold off until every expected word has come back
    bit         quiet;  // no idle gap after this word
  } scan_word_t;

  // one result word as the block presents it
  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] sel;
    logic       disp;
    logic       start;
    logic [7:0] tx;
    logic       txv;
  } readout_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = adcvm_pkg::OP_TICK;
  logic [7:0] sample = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] seg_code;
  logic [7:0] digit_select;
  logic       display_valid;
  logic       start_conversion;
  logic [7:0] tx_byte;
  logic       tx_valid;

  // stimulus and prediction stores
  scan_word_t pending_words[$];
  readout_t   expected_readouts[$];

  // display model: buffered segment bytes and the scan position
  logic [7:0] glyph_buf [NUM_DIGITS];
  logic [3:0] scan_pos;

  int failures = 0;
  int results_seen = 0;

  adc_voltmeter_seven_segment_scanner #(
    .NUM_DIGITS(NUM_DIGITS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .seg_code         (seg_code),
    .digit_select     (digit_select),
    .display_valid    (display_valid),
    .start_conversion (start_conversion),
    .tx_byte          (tx_byte),
    .tx_valid         (tx_valid)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // display prediction
  // --------------------------------------------------------------------------

  // a sample rewrites the whole buffer; a tick reads one entry and advances
  function automatic void predict_readout(logic w_op, logic [7:0] n);
    readout_t   r;
    int         tenths;
    int         mag;
    logic [2:0] pos;
    r = '0;
    if (w_op == adcvm_pkg::OP_SAMPLE) begin
      // 125/128 scale with a 125 tenths offset, truncated toward zero
      tenths = (125 * int'(n) - 16000) / 128;
      mag = (tenths < 0) ? -tenths : tenths;
      glyph_buf[0] = adcvm_pkg::SEG_H;
      glyph_buf[1] = DIGIT_GLYPH[n[3:0]];
      glyph_buf[2] = DIGIT_GLYPH[n[7:4]];
      glyph_buf[3] = adcvm_pkg::SEG_BLANK;
      glyph_buf[4] = DIGIT_GLYPH[mag % 10];
      glyph_buf[5] = DIGIT_GLYPH[(mag / 10) % 10] | adcvm_pkg::SEG_DP;
      glyph_buf[6] = DIGIT_GLYPH[(mag / 100) % 10];
      // a value that truncates to zero from below shows no minus sign
      glyph_buf[7] = (tenths < 0) ? adcvm_pkg::SEG_MINUS : adcvm_pkg::SEG_BLANK;
      r.seg = adcvm_pkg::SEG_BLANK;
      r.sel = adcvm_pkg::SEL_OFF;
      r.tx  = n;
      r.txv = 1'b1;
    end else begin
      // the wrap happens on the tick after the last digit, which also starts
      // a conversion
      if (scan_pos >= NUM_DIGITS) begin
        r.start  = 1'b1;
        scan_pos = '0;
      end
      pos = scan_pos[2:0];
      r.seg  = glyph_buf[pos];
      r.sel  = ~(8'h01 << pos);
      r.disp = 1'b1;
      scan_pos = scan_pos + 4'd1;
    end
    expected_readouts.push_back(r);
  endfunction

  function automatic void compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  function automatic void queue_word(logic w_op, logic [7:0] s, bit drain, bit quiet);
    scan_word_t w;
    w.op = w_op;
    w.sample = s;
    w.drain = drain;
    w.quiet = quiet;
    pending_words.push_back(w);
  endfunction

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  scan_word_t cur_word;
  bit         presenting = 1'b0;
  int         tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      presenting = 1'b0;
      tx_gap = 0;
      for (int i = 0; i < NUM_DIGITS; i++) glyph_buf[i] = adcvm_pkg::SEG_BLANK;
      scan_pos = '0;
      in_valid <= 1'b0;
    end else begin
      // word taken this edge: predict it and draw the gap before the next one
      if (in_valid && !in_stall) begin
        predict_readout(cur_word.op, cur_word.sample);
        presenting = 1'b0;
        tx_gap = cur_word.quiet ? 0 : $urandom_range(0, 15);
      end
      if (!presenting && pending_words.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!(pending_words[0].drain && expected_readouts.size() != 0)) begin
          cur_word = pending_words.pop_front();
          presenting = 1'b1;
        end
      end
      // payload only moves when a new word is loaded, so a stalled word holds
      in_valid <= presenting;
      op       <= cur_word.op;
      sample   <= cur_word.sample;
    end
  end

  // --------------------------------------------------------------------------
  // output monitor and checker
  // --------------------------------------------------------------------------
  readout_t want;
  int       rx_hold = 0;
  bit       rx_quiet;

  always @(posedge clk) begin
    if (rst) begin
      rx_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readouts.size() == 0) begin
          $display("%0t unexpected result word: seg %h sel %h tx %h", $time,
                   seg_code, digit_select, tx_byte);
          failures++;
        end else begin
          want = expected_readouts.pop_front();
          compare_field("seg_code", seg_code, want.seg);
          compare_field("digit_select", digit_select, want.sel);
          compare_field("display_valid", 8'(display_valid), 8'(want.disp));
          compare_field("start_conversion", 8'(start_conversion), 8'(want.start));
          compare_field("tx_byte", tx_byte, want.tx);
          compare_field("tx_valid", 8'(tx_valid), 8'(want.txv));
        end
        results_seen++;
        // every fourth stretch of words is taken back to back
        rx_quiet = ((results_seen / 48) % 4) == 2;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: nothing moving for too long means a hang
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int         made;
    int         ticks;
    bit         quiet;
    bit         drain;
    logic [7:0] n;

    // blank buffer after reset, and the first start on the ninth tick
    repeat (9) queue_word(adcvm_pkg::OP_TICK, 8'($urandom), 1'b0, 1'b0);
    // most negative reading, loaded only once the display is drained
    queue_word(adcvm_pkg::OP_SAMPLE, 8'h00, 1'b1, 1'b0);
    repeat (8) queue_word(adcvm_pkg::OP_TICK, 8'($urandom), 1'b0, 1'b0);
    // just below midscale truncates to zero without a minus sign
    queue_word(adcvm_pkg::OP_SAMPLE, 8'h7f, 1'b0, 1'b0);
    queue_word(adcvm_pkg::OP_SAMPLE, 8'h80, 1'b0, 1'b0);
    // largest positive reading
    queue_word(adcvm_pkg::OP_SAMPLE, 8'hff, 1'b0, 1'b1);
    repeat (4) queue_word(adcvm_pkg::OP_TICK, 8'($urandom), 1'b0, 1'b1);

    // random part: mostly a sample followed by a scan of ticks, some noise
    made = 0;
    while (made < 1030) begin
      quiet = ((made / 40) % 5) == 3;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       n = 8'h00;
          1:       n = 8'hff;
          2:       n = 8'h7f + 8'($urandom_range(0, 2));
          default: n = 8'($urandom);
        endcase
        drain = (made % 150) > 140 && $urandom_range(0, 3) == 0;
        queue_word(adcvm_pkg::OP_SAMPLE, n, drain, quiet);
        made++;
        ticks = $urandom_range(1, 12);
        repeat (ticks) queue_word(adcvm_pkg::OP_TICK, 8'($urandom), 1'b0, quiet);
        made += ticks;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_word($urandom_range(0, 1) ? adcvm_pkg::OP_SAMPLE : adcvm_pkg::OP_TICK,
                     8'($urandom), 1'b0, quiet);
          made++;
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // everything sent, then every prediction answered
    while (pending_words.size() != 0 || presenting || expected_readouts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
